>>> design/ltc_pkg.sv
// Shared types and constants for the language tag checker.
// Holds the length limits, the counter widths, the status codes and the state record.
// Used by ltc_step and language_tag_check_truncate.
`default_nettype none

package ltc_pkg;

  // Length limits of the tag and of its subtags.
  localparam int unsigned MaxTagLen     = 15;
  localparam int unsigned MaxSubtagLen  = 8;
  localparam int unsigned MaxPrimaryLen = 3;

  // Counters saturate one above their largest compared value.
  localparam int unsigned SubCap = ((MaxSubtagLen > MaxPrimaryLen) ?
                                    MaxSubtagLen : MaxPrimaryLen) + 1;
  localparam int unsigned PosCap = MaxTagLen + 1;

  localparam int unsigned PosW  = $clog2(PosCap + 1);
  localparam int unsigned SubW  = $clog2(SubCap + 1);
  localparam int unsigned KeptW = $clog2(MaxTagLen + 1);

  localparam int unsigned CharW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LenW    = 4;

  localparam logic [CharW-1:0] CharEnd    = 8'h00;
  localparam logic [CharW-1:0] CharDash   = 8'h2d;
  localparam logic [CharW-1:0] CharUscore = 8'h5f;

  typedef enum logic [StatusW-1:0] {
    StWhole   = 2'd0,
    StTrunc   = 2'd1,
    StInvalid = 2'd2
  } status_e;

  typedef struct packed {
    logic [PosW-1:0]  position;
    logic [SubW-1:0]  subtag_length;
    logic [KeptW-1:0] kept_end;
    logic             in_primary;
    logic             stopped_truncated;
    logic             bad_seen;
  } ltc_state_t;

  typedef struct packed {
    logic            valid;
    status_e         status;
    logic [LenW-1:0] kept_length;
  } ltc_result_t;

  localparam ltc_state_t StateReset = '{
    position:          '0,
    subtag_length:     '0,
    kept_end:          '0,
    in_primary:        1'b1,
    stopped_truncated: 1'b0,
    bad_seen:          1'b0
  };

endpackage

`default_nettype wire

>>> design/ltc_step.sv
// Per-byte update of the tag checker state and the result on the ending byte.
// Purely combinational; depends on ltc_pkg.
`default_nettype none

module ltc_step (
  input  ltc_pkg::ltc_state_t  state_i,
  input  logic [7:0]           char_i,
  output ltc_pkg::ltc_state_t  state_o,
  output ltc_pkg::ltc_result_t result_o
);
  import ltc_pkg::*;

  logic       is_sep;
  logic       is_word;
  logic       is_end;
  logic       last;
  ltc_state_t closed;

  assign is_end  = (char_i == CharEnd);
  assign is_sep  = (char_i == CharDash) || (char_i == CharUscore);
  assign is_word = ((char_i >= 8'h41) && (char_i <= 8'h5a)) ||
                   ((char_i >= 8'h61) && (char_i <= 8'h7a)) ||
                   ((char_i >= 8'h30) && (char_i <= 8'h39));
  assign last    = is_end;

  // Examination of the subtag that ends at the current position.
  always_comb begin
    closed = state_i;
    if (state_i.in_primary) begin
      if ((state_i.subtag_length == '0) ||
          (state_i.subtag_length > SubW'(MaxPrimaryLen))) begin
        closed.bad_seen = 1'b1;
      end
      closed.in_primary = 1'b0;
    end
    if (!closed.stopped_truncated && !closed.bad_seen) begin
      priority if (state_i.subtag_length > SubW'(MaxSubtagLen)) begin
        closed.bad_seen = 1'b1;
      end else if (state_i.position > PosW'(MaxTagLen)) begin
        closed.stopped_truncated = 1'b1;
      end else if (state_i.subtag_length >= SubW'(2)) begin
        closed.kept_end = state_i.position[KeptW-1:0];
      end else if (last) begin
        closed.bad_seen = 1'b1;
      end else begin
        // A short subtag that is not the last one is skipped.
        closed.kept_end = state_i.kept_end;
      end
    end
    closed.subtag_length = '0;
  end

  always_comb begin
    state_o              = state_i;
    result_o.valid       = 1'b0;
    result_o.status      = StWhole;
    result_o.kept_length = '0;
    if (!is_end) begin
      if (is_sep) begin
        state_o = closed;
      end else begin
        if (!is_word) begin
          state_o.bad_seen = 1'b1;
        end
        if (state_i.subtag_length < SubW'(SubCap)) begin
          state_o.subtag_length = state_i.subtag_length + SubW'(1);
        end
      end
      if (state_i.position < PosW'(PosCap)) begin
        state_o.position = state_i.position + PosW'(1);
      end
    end else begin
      state_o        = StateReset;
      result_o.valid = 1'b1;
      if (state_i.position != '0) begin
        if (closed.bad_seen || (closed.kept_end <= KeptW'(1))) begin
          result_o.status = StInvalid;
        end else begin
          result_o.status      = closed.stopped_truncated ? StTrunc : StWhole;
          result_o.kept_length = LenW'(closed.kept_end);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/language_tag_check_truncate.sv
// Top level of the language tag checker with truncation.
// Holds the input register, the tag state and the result register; depends on
// ltc_pkg and ltc_step.
//
// The block takes a language tag one byte per transfer, a zero byte ending it,
// and gives one result transfer per tag: a status (accepted whole, accepted
// truncated, or invalid) and the number of leading characters kept. Each byte
// is captured in an input register and, from there, updates the running
// state (position, subtag length, kept end and flags) through a single pass of
// small counter and compare logic. One byte per cycle is sustained; the only
// stall comes from the result register, which holds back an ending byte while
// an earlier result is still waiting to be taken. The result register is
// loaded when its ending byte leaves the input register, and the result is
// offered from then on. Bytes other than the ending one produce no result
// transfer.
`default_nettype none

module language_tag_check_truncate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    char_code_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ltc_pkg::StatusW-1:0]   status_o,
  output logic [ltc_pkg::LenW-1:0]      kept_length_o
);
  import ltc_pkg::*;

  // Input register stage.
  logic             s1_valid_q;
  logic [CharW-1:0] s1_char_q;
  logic             s1_fire;

  // Running tag state.
  ltc_state_t state_q, state_d;
  ltc_result_t result;

  // Result register.
  logic            out_valid_q;
  status_e         status_q;
  logic [LenW-1:0] kept_q;
  logic            out_free;

  // The result register can take a new value when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // A byte leaves the input register unless it is an ending byte that would
  // overwrite a result nobody has taken yet.
  assign s1_fire    = s1_valid_q && ((s1_char_q != CharEnd) || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;

  ltc_step u_step (
    .state_i  (state_q),
    .char_i   (s1_char_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_char_q <= char_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && result.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && result.valid) begin
      status_q <= result.status;
      kept_q   <= result.kept_length;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign kept_length_o = kept_q;

  // An invalid tag never reports kept characters.
  a_invalid_no_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StInvalid)) |-> (kept_length_o == '0))
    else $error("invalid result with nonzero kept length");

  // An accepted tag keeps either nothing (empty tag) or at least two characters.
  a_valid_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != StInvalid)) |-> (kept_length_o != LenW'(1)))
    else $error("accepted result with a kept length of one");

  // Truncation only happens with a kept subtag.
  a_trunc_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StTrunc)) |-> (kept_length_o >= LenW'(2)))
    else $error("truncated result with too short a kept length");

  // The ending byte returns the tag state to its reset value.
  a_end_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_char_q == CharEnd)) |=>
      ((state_q.position == '0) && state_q.in_primary && !state_q.bad_seen))
    else $error("tag state not cleared after ending byte");

  // Any other byte advances the position, which saturates at its cap.
  a_byte_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_char_q != CharEnd)) |=> (state_q.position != '0))
    else $error("position did not advance");

endmodule

`default_nettype wire
